[design/chacha_pkg.sv]
// ----------------------------------------------------------------------------
// ChaCha20 package
// Shared constants and types for the stream cipher core.
// ----------------------------------------------------------------------------
package chacha_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegKey01   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey23   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey45   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey67   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNonce01 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegNonce2  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCounter = 3'd6;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  // Byte entry passed from the front queue to the back end
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

endpackage

[design/chacha_fifo.sv]
// ----------------------------------------------------------------------------
// ChaCha front queue
// Two-entry queue that accepts input bytes independent of the back end.
// ----------------------------------------------------------------------------
module chacha_fifo import chacha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  byte_item_t in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output byte_item_t out_item_o
);

  byte_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_item_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[design/chacha_round.sv]
// ----------------------------------------------------------------------------
// ChaCha block engine
// Runs one quarter round per cycle on the 16-word state, then feed-forward.
// ----------------------------------------------------------------------------
module chacha_round import chacha_pkg::*; #(
  parameter int unsigned DoubleRounds = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [511:0]   init_i,
  output logic           done_o,
  output logic [511:0]   block_o
);

  localparam int unsigned StepW = $clog2(DoubleRounds * 8 + 1);

  typedef enum logic [1:0] {StIdle, StRound, StAdd} state_e;

  state_e             state_q;
  logic [StepW-1:0]   step_q;
  logic [31:0]        w_q [16];
  logic [3:0]         ia, ib, ic, id;
  logic [31:0]        a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2;
  logic [2:0]         qsel;

  assign qsel = step_q[2:0];

  // Select lanes of this quarter round
  always_comb begin
    case (qsel)
      3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
      3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
      3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
      3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
      3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
      3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
      3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
      default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
    endcase
  end

  // Quarter round datapath
  always_comb begin
    a0 = w_q[ia] + w_q[ib];
    d0 = rotl(w_q[id] ^ a0, 16);
    c0 = w_q[ic] + d0;
    b0 = rotl(w_q[ib] ^ c0, 12);
    a1 = a0 + b0;
    d1 = rotl(d0 ^ a1, 8);
    c1 = c0 + d1;
    b1 = rotl(b0 ^ c1, 7);
    a2 = a1; b2 = b1; c2 = c1; d2 = d1;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (start_i) begin
          for (int i = 0; i < 16; i++) w_q[i] <= init_i[32*i +: 32];
        end
      end
      StRound: begin
        w_q[ia] <= a2; w_q[ib] <= b2; w_q[ic] <= c2; w_q[id] <= d2;
      end
      StAdd: begin
        for (int i = 0; i < 16; i++) w_q[i] <= w_q[i] + init_i[32*i +: 32];
      end
      default: ;
    endcase
  end

  // Sequence the rounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        StIdle: begin
          step_q <= '0;
          if (start_i) state_q <= StRound;
        end
        StRound: begin
          step_q <= step_q + 1'b1;
          if (step_q == StepW'(DoubleRounds * 8 - 1)) state_q <= StAdd;
        end
        StAdd: begin
          state_q <= StIdle;
          done_o  <= 1'b1;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  for (genvar g = 0; g < 16; g++) begin : g_out
    assign block_o[32*g +: 32] = w_q[g];
  end

endmodule

[design/chacha20_stream_cipher_core.sv]
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher core
// XORs message bytes with the ChaCha20 keystream.
// ----------------------------------------------------------------------------
// Usage: write key, nonce and counter through cfg_* (index 0..6) while idle;
// any write to index 0..6 restarts the keystream, index 6 also reloads the block counter.
// Bytes enter on in_* (valid/ready) into a two-entry queue; the back end
// takes one, XORs it with the current keystream byte and places the result
// in an output register drained on out_* (valid/ready).
// The back end handles one byte at a time while a keystream block is valid. The first byte of
// each block waits for the block engine: DOUBLE_ROUNDS*8 quarter rounds, then the
// feed-forward add, one quarter round per cycle in a single shared unit.
// A byte marked last, or the 64th byte of a block, advances the counter.
// Reset clears the configuration and control registers to zero and drops queued bytes.
// A stalled receiver holds out_valid_o with stable payload; the queue fills
// and then in_ready_o drops.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_core import chacha_pkg::*; #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_message_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o
);

  typedef enum logic [1:0] {StWait, StGen, StXor} state_e;

  logic [63:0] key01_q, key23_q, key45_q, key67_q, nonce01_q;
  logic [31:0] nonce2_q, counter_q;
  logic [5:0]  pos_q;
  logic        bvalid_q;
  state_e      state_q;
  logic        gen_start, gen_done;
  logic [511:0] init_w, blk_w;
  byte_item_t  in_item, q_item;
  logic        q_valid, q_ready;
  logic        cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign in_item     = '{data: data_byte_i, last: end_of_message_i};

  chacha_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_item_i(in_item),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_item_o(q_item)
  );

  assign init_w = {nonce2_q, nonce01_q, counter_q, key67_q, key45_q, key23_q,
                   key01_q, Sigma3, Sigma2, Sigma1, Sigma0};

  // The engine holds the finished block until the next start
  chacha_round #(.DoubleRounds(DOUBLE_ROUNDS)) u_round (
    .clk_i, .rst_ni, .start_i(gen_start), .init_i(init_w),
    .done_o(gen_done), .block_o(blk_w)
  );

  assign gen_start = (state_q == StWait) && q_valid && !bvalid_q;
  assign q_ready   = (state_q == StXor) && (!out_valid_o || out_ready_i);

  // Config, back-end sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key01_q <= '0; key23_q <= '0; key45_q <= '0; key67_q <= '0;
      nonce01_q <= '0; nonce2_q <= '0; counter_q <= '0;
      pos_q <= '0; bvalid_q <= 1'b0; state_q <= StWait;
      out_valid_o <= 1'b0; out_byte_o <= '0; out_last_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        StWait: begin
          if (q_valid) state_q <= bvalid_q ? StXor : StGen;
        end
        StGen: begin
          if (gen_done) begin
            bvalid_q <= 1'b1;
            pos_q    <= '0;
            state_q  <= StXor;
          end
        end
        StXor: begin
          if (q_ready) begin
            out_valid_o <= 1'b1;
            out_byte_o  <= q_item.data ^ blk_w[{pos_q, 3'b000} +: 8];
            out_last_o  <= q_item.last;
            pos_q       <= pos_q + 6'd1;
            if (pos_q == 6'd63 || q_item.last) begin
              counter_q <= counter_q + 32'd1;
              bvalid_q  <= 1'b0;
              pos_q     <= '0;
            end
            state_q <= StWait;
          end
        end
        default: state_q <= StWait;
      endcase
      if (cfg_fire) begin
        case (cfg_index_i)
          RegKey01:   key01_q   <= cfg_data_i;
          RegKey23:   key23_q   <= cfg_data_i;
          RegKey45:   key45_q   <= cfg_data_i;
          RegKey67:   key67_q   <= cfg_data_i;
          RegNonce01: nonce01_q <= cfg_data_i;
          RegNonce2:  nonce2_q  <= cfg_data_i[31:0];
          RegCounter: counter_q <= cfg_data_i[31:0];
          default: ;
        endcase
        if (cfg_index_i <= RegCounter) begin
          bvalid_q <= 1'b0;
          pos_q    <= '0;
        end
      end
    end
  end

endmodule

[verif/tb_chacha20_stream_cipher_core.sv]
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher core testbench
// Drives key, nonce and counter settings and byte streams with random gaps
// and output stalls; predicts each output byte with an in-bench ChaCha20
// keystream model and checks every output transaction in order.
// ----------------------------------------------------------------------------
module tb_chacha20_stream_cipher_core;
  import chacha_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Rounds   = 10;
  localparam int unsigned NumBytes = 1200;
  localparam int unsigned MaxCycles = 600000;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } cipher_byte_t;

  int unsigned n_errors = 0;
  int unsigned n_checked = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  // --------------------------------------------------------------------------
  // Keystream predictor and queue of expected output bytes
  // --------------------------------------------------------------------------
  class cipher_scoreboard;
    logic [63:0] regs [7];
    logic [31:0] counter;
    logic [7:0]  stream [64];
    int unsigned pos;
    bit          have_block;
    cipher_byte_t pending [$];

    function new();
      foreach (regs[i]) regs[i] = '0;
      counter = '0;
      pos = 0;
      have_block = 0;
    endfunction

    function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
      if (idx > RegCounter) return;
      regs[idx] = val;
      if (idx == RegNonce2 || idx == RegCounter) regs[idx] = {32'h0, val[31:0]};
      if (idx == RegCounter) counter = val[31:0];
      have_block = 0;
      pos = 0;
    endfunction

    function logic [31:0] rot(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter(ref logic [31:0] w [16], input int a, b, c, d);
      w[a] += w[b]; w[d] = rot(w[d] ^ w[a], 16);
      w[c] += w[d]; w[b] = rot(w[b] ^ w[c], 12);
      w[a] += w[b]; w[d] = rot(w[d] ^ w[a], 8);
      w[c] += w[d]; w[b] = rot(w[b] ^ w[c], 7);
    endfunction

    function void build_block();
      logic [31:0] init [16];
      logic [31:0] w [16];
      init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
      for (int k = 0; k < 4; k++) begin
        init[4 + 2*k] = regs[k][31:0];
        init[5 + 2*k] = regs[k][63:32];
      end
      init[12] = counter;
      init[13] = regs[RegNonce01][31:0];
      init[14] = regs[RegNonce01][63:32];
      init[15] = regs[RegNonce2][31:0];
      w = init;
      for (int r = 0; r < Rounds; r++) begin
        quarter(w, 0, 4, 8, 12);  quarter(w, 1, 5, 9, 13);
        quarter(w, 2, 6, 10, 14); quarter(w, 3, 7, 11, 15);
        quarter(w, 0, 5, 10, 15); quarter(w, 1, 6, 11, 12);
        quarter(w, 2, 7, 8, 13);  quarter(w, 3, 4, 9, 14);
      end
      for (int k = 0; k < 16; k++) begin
        logic [31:0] v;
        v = w[k] + init[k];
        for (int b = 0; b < 4; b++) stream[4*k + b] = v[8*b +: 8];
      end
    endfunction

    // Note an accepted input byte and queue its expected output
    function void note_input(input logic [7:0] data, input logic last);
      cipher_byte_t e;
      if (!have_block) begin
        build_block();
        have_block = 1;
        pos = 0;
      end
      e.data = data ^ stream[pos];
      e.last = last;
      pending.push_back(e);
      pos = (pos + 1) % 64;
      if (pos == 0 || last) begin
        counter++;
        have_block = 0;
        pos = 0;
      end
    endfunction

    // Compare an output transaction with the oldest expectation
    task check_output(input logic [7:0] data, input logic last);
      cipher_byte_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected output byte %02h", data));
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (data !== e.data)
        report_mismatch($sformatf("out_byte %02h, want %02h", data, e.data));
      if (last !== e.last)
        report_mismatch($sformatf("out_last %0b, want %0b", last, e.last));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [63:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         data_byte;
  logic               end_of_message;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         out_byte;
  logic               out_last;

  cipher_scoreboard sb = new();
  longint unsigned cycle = 0;
  int unsigned n_sent = 0;
  int unsigned n_msgs = 0;
  int unsigned n_cfg = 0;
  int unsigned stall_mode = 0;

  chacha20_stream_cipher_core #(.DOUBLE_ROUNDS(Rounds)) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .data_byte_i     (data_byte),
    .end_of_message_i(end_of_message),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_byte_o      (out_byte),
    .out_last_o      (out_last)
  );

  // Generate clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watch for a hung run
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MaxCycles) begin
      $display("timeout after %0d cycles", cycle);
      $display("** chacha20_stream_cipher_core: FAILED **");
      $finish;
    end
  end

  // Check output transactions
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_output(out_byte, out_last);
  end

  // Stall the receiver: mode 0 never, 1 light, 2 heavy, 3 long runs
  always @(negedge clk) begin
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) != 0);
      2: out_ready <= ($urandom_range(0, 2) == 0);
      default: begin
        if ($urandom_range(0, 15) == 0) out_ready <= ~out_ready;
      end
    endcase
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
  end

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold the byte until accepted; keep valid high across back-to-back bytes,
  // otherwise drop valid before the next byte
  task automatic send_byte(input logic [7:0] data, input logic last, input bit keep);
    in_valid       <= 1'b1;
    data_byte      <= data;
    end_of_message <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_input(data, last);
    n_sent++;
    if (last) n_msgs++;
    @(negedge clk);
    if (!keep) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Send a message in bursts with random gaps
  task automatic send_message(input int unsigned len);
    int unsigned burst;
    burst = $urandom_range(1, 20);
    for (int unsigned k = 0; k < len; k++) begin
      bit last;
      bit gap;
      last = (k == len - 1);
      burst--;
      gap = (burst == 0) || last;
      send_byte(8'($urandom_range(0, 255)), last, !gap);
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end
    end
  endtask

  // Wait for all outputs, plus a block time for safety before a register write
  task automatic drain();
    int unsigned guard;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (Rounds * 8 + 20) @(negedge clk);
  endtask

  task automatic load_settings(input logic [63:0] k0, k1, k2, k3, n01,
                               input logic [31:0] n2, ctr);
    write_cfg(RegKey01, k0);
    write_cfg(RegKey23, k1);
    write_cfg(RegKey45, k2);
    write_cfg(RegKey67, k3);
    write_cfg(RegNonce01, n01);
    write_cfg(RegNonce2, {32'h0, n2});
    write_cfg(RegCounter, {32'h0, ctr});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    cfg_valid = 1'b0;
    cfg_index = RegKey01;
    cfg_data = '0;
    in_valid = 1'b0;
    data_byte = '0;
    end_of_message = 1'b0;
    out_ready = 1'b1;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: reset settings, extremes of byte values, last flags
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h5a, 1'b1, 1'b0);
    send_byte(8'ha5, 1'b1, 1'b0);
    drain();

    // Directed: all-ones settings, counter wrap, full block with last on byte 64
    load_settings('1, '1, '1, '1, '1, '1, 32'hffff_ffff);
    for (int k = 0; k < 64; k++) send_byte(k[7:0] ^ 8'hc3, (k == 63), 1'b1);
    send_byte(8'hff, 1'b0, 1'b0);
    drain();

    // Directed: out-of-range index is dropped; rewrite of one key word between messages
    write_cfg(CfgIdxW'(RegCounter + 1), rand64());
    write_cfg(RegKey23, 64'h0123_4567_89ab_cdef);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h01, 1'b1, 1'b0);
    drain();

    // Random phases: new settings, then a batch of messages
    while (n_sent < NumBytes - 75) begin
      case ($urandom_range(0, 3))
        0: load_settings(rand64(), rand64(), rand64(), rand64(), rand64(),
                         $urandom(), $urandom());
        1: load_settings('0, '0, '0, '0, '0, '0, 32'hffff_fffe);
        2: write_cfg(CfgIdxW'($urandom_range(0, 7)), rand64());
        default: write_cfg(RegCounter, {32'h0, $urandom()});
      endcase
      repeat ($urandom_range(2, 6)) begin
        int unsigned len;
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(64, 150)
                                          : $urandom_range(1, 40);
        send_message(len);
      end
      drain();
    end

    stall_mode = 0;
    drain();
    $display("Checked %0d output bytes from %0d messages over %0d register writes.",
             n_checked, n_msgs, n_cfg);
    if (n_errors == 0 && sb.pending.size() == 0) begin
      $display("** chacha20_stream_cipher_core: PASSED **");
    end else begin
      $display("%0d mismatches, %0d bytes outstanding", n_errors, sb.pending.size());
      $display("** chacha20_stream_cipher_core: FAILED **");
    end
    $finish;
  end

endmodule
